// ===== rtl/tmpr_pkg.sv =====
`default_nettype none
// ============================================================================
// tmpr_pkg: shared types and constants of the tile map pixel renderer
// Video memory geometry, control bit positions, command codes, grey palette.
// ============================================================================
package tmpr_pkg;

    localparam int VRAM_BYTES = 8192;

    // Offsets from the start of video memory (0x8000)
    localparam logic [15:0] MAP0_OFFSET       = 16'h1800; // 0x9800
    localparam logic [15:0] MAP1_OFFSET       = 16'h1C00; // 0x9C00
    localparam logic [15:0] SIGNED_LOW_OFFSET = 16'h0800; // 0x8800, tile -128

    localparam int LCDC_MAP_BIT  = 6;
    localparam int LCDC_DATA_BIT = 4;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_RENDER = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_MAP,
        ST_LO,
        ST_HI
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] shade;
    } t_shade_evt;

    function automatic logic [31:0] grey_argb(input logic [1:0] shade);
        logic [31:0] argb;
        case (shade)
            2'd0:    argb = 32'hFFFF_FFFF;
            2'd1:    argb = 32'hFFAA_AAAA;
            2'd2:    argb = 32'hFF55_5555;
            default: argb = 32'hFF00_0000;
        endcase
        return argb;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tmpr_vram.sv =====
`default_nettype none
// ============================================================================
// tmpr_vram: single-port video memory
// One access per cycle, write or read, read data registered.
// ============================================================================
module tmpr_vram #(
    parameter int VRAM_BYTES = tmpr_pkg::VRAM_BYTES,
    localparam int ADDR_W    = $clog2(VRAM_BYTES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [7:0]        i_wdata,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [VRAM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/tmpr_seq.sv =====
`default_nettype none
// ============================================================================
// tmpr_seq: memory port sequencer
// Clears memory after reset, then runs writes and the three-read render walk.
// ============================================================================
module tmpr_seq #(
    parameter int VRAM_BYTES = tmpr_pkg::VRAM_BYTES,
    localparam int ADDR_W    = $clog2(VRAM_BYTES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_command,
    input  wire logic [12:0]           i_vram_offset,
    input  wire logic [7:0]            i_write_byte,
    input  wire logic [7:0]            i_pixel_x,
    input  wire logic [7:0]            i_pixel_y,
    input  wire logic [7:0]            i_lcd_control,
    input  wire logic [7:0]            i_mem_rdata,
    output logic                       o_busy,
    output logic                       o_mem_we,
    output logic      [ADDR_W-1:0]     o_mem_addr,
    output logic      [7:0]            o_mem_wdata,
    output tmpr_pkg::t_shade_evt       o_evt
);

    tmpr_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_row_addr;
    logic [2:0]        r_bit_sel;
    logic [2:0]        r_py_row;
    logic [7:0]        r_lo;
    logic              r_hi_pend;

    logic              accept;
    logic [15:0]       map_addr;
    logic [15:0]       tile_base;
    logic [15:0]       row_addr;

    assign accept = (r_state == tmpr_pkg::ST_MAP) && i_start;

    // Map entry: base of selected map plus {row of cells, column of cells}
    always_comb begin
        map_addr = (i_lcd_control[tmpr_pkg::LCDC_MAP_BIT] ? tmpr_pkg::MAP1_OFFSET
                                                           : tmpr_pkg::MAP0_OFFSET)
                 + {6'd0, i_pixel_y[7:3], i_pixel_x[7:3]};
    end

    // Tile pattern row from the tile index just read
    always_comb begin
        if (i_lcd_control[tmpr_pkg::LCDC_DATA_BIT]) begin
            tile_base = {4'd0, i_mem_rdata, 4'd0};
        end else begin
            tile_base = tmpr_pkg::SIGNED_LOW_OFFSET
                      + {4'd0, i_mem_rdata ^ 8'h80, 4'd0};
        end
        row_addr = tile_base + {12'd0, r_py_row, 1'b0};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmpr_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(VRAM_BYTES - 1)) begin
                    n_state = tmpr_pkg::ST_MAP;
                end
            end
            tmpr_pkg::ST_MAP: begin
                if (accept && (i_command == tmpr_pkg::CMD_RENDER)) begin
                    n_state = tmpr_pkg::ST_LO;
                end
            end
            tmpr_pkg::ST_LO: n_state = tmpr_pkg::ST_HI;
            tmpr_pkg::ST_HI: n_state = tmpr_pkg::ST_MAP;
            default:         n_state = tmpr_pkg::ST_CLEAR;
        endcase
    end

    // Memory port drive
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_addr  = map_addr[ADDR_W-1:0];
        o_mem_wdata = i_write_byte;
        unique case (r_state)
            tmpr_pkg::ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_clr_addr;
                o_mem_wdata = 8'd0;
            end
            tmpr_pkg::ST_MAP: begin
                if (accept && (i_command == tmpr_pkg::CMD_WRITE)) begin
                    o_mem_we   = 1'b1;
                    o_mem_addr = i_vram_offset[ADDR_W-1:0];
                end else begin
                    o_mem_addr = map_addr[ADDR_W-1:0];
                end
            end
            tmpr_pkg::ST_LO: o_mem_addr = row_addr[ADDR_W-1:0];
            tmpr_pkg::ST_HI: o_mem_addr = r_row_addr + ADDR_W'(1);
            default:         o_mem_addr = r_clr_addr;
        endcase
    end

    assign o_busy = (r_state != tmpr_pkg::ST_MAP);

    // High plane byte is on the read port the cycle after ST_HI
    assign o_evt.valid = r_hi_pend;
    assign o_evt.shade = {i_mem_rdata[~r_bit_sel], r_lo[~r_bit_sel]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tmpr_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_hi_pend  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hi_pend <= (r_state == tmpr_pkg::ST_HI);
            if (r_state == tmpr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bit_sel <= i_pixel_x[2:0];
            r_py_row  <= i_pixel_y[2:0];
        end
        if (r_state == tmpr_pkg::ST_LO) begin
            r_row_addr <= row_addr[ADDR_W-1:0];
        end
        if (r_state == tmpr_pkg::ST_HI) begin
            r_lo <= i_mem_rdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tile_map_pixel_renderer_top.sv =====
`default_nettype none
// ============================================================================
// tile_map_pixel_renderer_top: 2bpp background tile pixel renderer
// Video memory with byte writes and per-pixel map/tile lookup to grey ARGB.
// ============================================================================
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------
//  request   | in        | start, busy (taken !busy)   | command, vram_offset,
//            |           |                             | write_byte, pixel_x, pixel_y
//  result    | out       | o_done (one-cycle strobe)   | shade_index, pixel_argb
//  control   | in        | i_cfg_valid, o_cfg_ready    | cfg_data (lcd_control)
//
//  A write request is one port access. A render request makes three reads on the
//  single video memory port (map entry, low plane byte, high plane byte); no new
//  request is taken until the last is issued, and the result strobes once the high
//  plane byte has passed the read data and output registers. The next request is
//  taken while a result is still being formed. After reset the memory is swept to
//  zero, one byte a cycle, with busy high until done. The receiver cannot stall.
//
module tile_map_pixel_renderer_top #(
    parameter int VRAM_BYTES = tmpr_pkg::VRAM_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [12:0] i_vram_offset,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic [7:0]  i_pixel_x,
    input  wire logic [7:0]  i_pixel_y,
    // result
    output logic             o_done,
    output logic      [1:0]  o_shade_index,
    output logic      [31:0] o_pixel_argb,
    // control register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(VRAM_BYTES);

    logic [7:0]            r_lcd_control;
    logic                  r_done;
    logic [1:0]            r_shade;
    logic [31:0]           r_argb;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [7:0]            mem_wdata;
    logic [7:0]            mem_rdata;
    tmpr_pkg::t_shade_evt  evt;

    // Control register: always ready; the user must write it only while idle (not enforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcd_control <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lcd_control <= i_cfg_data;
        end
    end

    tmpr_seq #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_command     (i_command),
        .i_vram_offset (i_vram_offset),
        .i_write_byte  (i_write_byte),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_lcd_control (r_lcd_control),
        .i_mem_rdata   (mem_rdata),
        .o_busy        (busy),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .o_evt         (evt)
    );

    tmpr_vram #(
        .VRAM_BYTES (VRAM_BYTES)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Output registers: done is a strobe; shade and colour are held until the next result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt.valid) begin
            r_shade <= evt.shade;
            r_argb  <= tmpr_pkg::grey_argb(evt.shade);
        end
    end

    assign o_done        = r_done;
    assign o_shade_index = r_shade;
    assign o_pixel_argb  = r_argb;

endmodule
`default_nettype wire

// ===== tb/tile_map_pixel_renderer_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tile_map_pixel_renderer_top_test: self-checking bench for the tile renderer
// Drives video memory writes and pixel renders through the start/busy port,
// steps the LCD control byte through several settings between phases, and
// checks every strobed pixel against a shadow memory and lookup kept here.
// ============================================================================
module tile_map_pixel_renderer_top_test;

    localparam int CYCLE_LIMIT   = 300000; // covers the clear sweep
    localparam int WRITE_SETTLE  = 8;      // cycles for a trailing write to land
    localparam int RESULT_SETTLE = 12;     // render latency plus margin
    localparam int ITEMS_TARGET  = 650;

    // ------------------------------------------------------------------------
    // Shadow of the renderer: video memory, control byte, pending pixels
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        typedef struct {
            logic [1:0]  shade;
            logic [31:0] argb;
            logic [7:0]  x;
            logic [7:0]  y;
        } t_pixel;

        logic [7:0]  vram [tmpr_pkg::VRAM_BYTES];
        logic [7:0]  control;
        logic [31:0] grey_level [4];
        t_pixel      pending_pixels [$];
        int          mismatches;

        function new();
            foreach (vram[i]) vram[i] = 8'h00;
            control       = 8'h00;
            grey_level[0] = 32'hFFFF_FFFF;
            grey_level[1] = 32'hFFAA_AAAA;
            grey_level[2] = 32'hFF55_5555;
            grey_level[3] = 32'hFF00_0000;
            mismatches    = 0;
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void set_control(input logic [7:0] value);
            control = value;
        endfunction

        // Map entry of the tile cell holding pixel (x, y)
        function logic [12:0] map_address(input logic [7:0] x, input logic [7:0] y);
            logic [12:0] base;
            base = control[tmpr_pkg::LCDC_MAP_BIT] ? 13'(tmpr_pkg::MAP1_OFFSET)
                                                   : 13'(tmpr_pkg::MAP0_OFFSET);
            return base + {3'b000, y[7:3], x[7:3]};
        endfunction

        // Low plane byte of one row of a tile; the high plane byte follows it
        function logic [12:0] row_address(input logic [7:0] tile, input logic [2:0] row);
            logic [12:0] base;
            if (control[tmpr_pkg::LCDC_DATA_BIT]) begin
                base = {1'b0, tile, 4'h0};
            end else begin
                base = 13'(tmpr_pkg::SIGNED_LOW_OFFSET) + {1'b0, tile ^ 8'h80, 4'h0};
            end
            return base + {9'd0, row, 1'b0};
        endfunction

        function void note_request(input tmpr_pkg::t_cmd cmd, input logic [12:0] offset,
                                   input logic [7:0] data, input logic [7:0] x,
                                   input logic [7:0] y);
            logic [7:0]  tile;
            logic [7:0]  lo;
            logic [7:0]  hi;
            logic [12:0] row_addr;
            logic [2:0]  bit_pos;
            t_pixel      pix;
            if (cmd == tmpr_pkg::CMD_WRITE) begin
                vram[offset] = data;
            end else begin
                tile      = vram[map_address(x, y)];
                row_addr  = row_address(tile, y[2:0]);
                lo        = vram[row_addr];
                hi        = vram[13'(row_addr + 13'd1)];
                bit_pos   = 3'd7 - x[2:0];
                pix.shade = {hi[bit_pos], lo[bit_pos]};
                pix.argb  = grey_level[pix.shade];
                pix.x     = x;
                pix.y     = y;
                pending_pixels.push_back(pix);
            end
        endfunction

        task check_result(input logic [1:0] shade, input logic [31:0] argb);
            t_pixel pix;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel out with none pending (shade %0d)", shade));
            end else begin
                pix = pending_pixels.pop_front();
                if (shade !== pix.shade)
                    report_mismatch($sformatf("pixel (%0d,%0d) shade %0d, want %0d",
                                              pix.x, pix.y, shade, pix.shade));
                if (argb !== pix.argb)
                    report_mismatch($sformatf("pixel (%0d,%0d) argb %h, want %h",
                                              pix.x, pix.y, argb, pix.argb));
            end
        endtask

        function int pending_count();
            return pending_pixels.size();
        endfunction

        task flag_leftovers();
            foreach (pending_pixels[i])
                report_mismatch($sformatf("pixel (%0d,%0d) never came out",
                                          pending_pixels[i].x, pending_pixels[i].y));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block hookup
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [12:0] i_vram_offset;
    logic [7:0]  i_write_byte;
    logic [7:0]  i_pixel_x;
    logic [7:0]  i_pixel_y;
    logic        o_done;
    logic [1:0]  o_shade_index;
    logic [31:0] o_pixel_argb;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    pixel_scoreboard sb = new();
    int              cycle_count = 0;
    int              items_sent  = 0;
    bit              no_idle     = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tile_map_pixel_renderer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_vram_offset (i_vram_offset),
        .i_write_byte  (i_write_byte),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_done        (o_done),
        .o_shade_index (o_shade_index),
        .o_pixel_argb  (o_pixel_argb),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Abort a hung run; the limit leaves room for the clear sweep
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Results cannot be stalled: check every strobe at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_shade_index, o_pixel_argb);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Random idle gap, or none at all during a back-to-back stretch
    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    // Present one request, hold it until taken, then idle for gap cycles.
    // With gap 0 start stays high and the caller must present the next one.
    task automatic send_request(input tmpr_pkg::t_cmd cmd, input logic [12:0] offset,
                                input logic [7:0] data, input logic [7:0] x,
                                input logic [7:0] y, input int gap);
        start         <= 1'b1;
        i_command     <= cmd;
        i_vram_offset <= offset;
        i_write_byte  <= data;
        i_pixel_x     <= x;
        i_pixel_y     <= y;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(cmd, offset, data, x, y);
        items_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start, wait out every pending pixel, then let a last write settle
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (WRITE_SETTLE) @(posedge i_clk);
    endtask

    // Call only while the block is idle
    task automatic write_control(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.set_control(value);
    endtask

    // Well-formed sequence: point a map cell at a tile, fill one pattern row,
    // then render pixels of that row, often back to back with the writes
    task automatic run_tile_row();
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  tile;
        logic [12:0] lo_addr;
        int          renders;
        x       = 8'($urandom);
        y       = 8'($urandom);
        tile    = 8'($urandom);
        lo_addr = sb.row_address(tile, y[2:0]);
        renders = $urandom_range(1, 3);
        send_request(tmpr_pkg::CMD_WRITE, sb.map_address(x, y), tile,
                     8'($urandom), 8'($urandom), draw_gap());
        send_request(tmpr_pkg::CMD_WRITE, lo_addr, 8'($urandom),
                     8'($urandom), 8'($urandom), draw_gap());
        send_request(tmpr_pkg::CMD_WRITE, 13'(lo_addr + 13'd1), 8'($urandom),
                     8'($urandom), 8'($urandom), draw_gap());
        repeat (renders) begin
            send_request(tmpr_pkg::CMD_RENDER, 13'($urandom), 8'($urandom),
                         {x[7:3], 3'($urandom)}, y, draw_gap());
        end
    endtask

    // Broken sequence: map entry written, then a pixel of that cell rendered unfilled
    task automatic run_stray_row();
        logic [7:0] x;
        logic [7:0] y;
        x = 8'($urandom);
        y = 8'($urandom);
        send_request(tmpr_pkg::CMD_WRITE, sb.map_address(x, y), 8'($urandom),
                     8'($urandom), 8'($urandom), draw_gap());
        send_request(tmpr_pkg::CMD_RENDER, 13'($urandom), 8'($urandom), x,
                     {y[7:3], 3'($urandom)}, draw_gap());
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [7:0] phase_control [8];

    initial begin
        int kind;
        int phase_items;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= tmpr_pkg::CMD_WRITE;
        i_vram_offset <= '0;
        i_write_byte  <= '0;
        i_pixel_x     <= '0;
        i_pixel_y     <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: control at reset value (map at 0x9800, signed tiles).
        // Render from cleared memory, before anything is written.
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd0, 8'd0, 0);
        // Map cell 0 -> tile -128 (0x8800); fill its first row and read it
        // straight back, exercising write-then-read with no gap
        send_request(tmpr_pkg::CMD_WRITE, 13'h1800, 8'h80, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h0800, 8'hA5, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h0801, 8'h3C, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h1FFF, 8'hFF, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd1, 8'd0, 1);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd2, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd7, 8'd0, 3);
        // Off-screen corner: last map cell -> tile +127 (top of the signed area)
        send_request(tmpr_pkg::CMD_WRITE, 13'h1BFF, 8'h7F, 8'd255, 8'd255, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h17FE, 8'h81, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h17FF, 8'hFF, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd255, 8'd255, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd248, 8'd255, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd249, 8'd255, 2);
        // Extremes of offset and data; pixel fields ignored on writes
        send_request(tmpr_pkg::CMD_WRITE, 13'h1FFF, 8'hFF, 8'd255, 8'd255, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h0000, 8'h00, 8'd255, 8'd255, 0);
        // Last visible pixel; offset and data fields ignored on renders
        send_request(tmpr_pkg::CMD_RENDER, 13'h1FFF, 8'hFF, 8'd159, 8'd143, 1);
        wait_idle();

        // Directed: upper map, unsigned tile data
        write_control(8'hFF);
        send_request(tmpr_pkg::CMD_WRITE, 13'h1C00, 8'hFF, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h0FF0, 8'h0F, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_WRITE, 13'h0FF1, 8'hF0, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd0, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd4, 8'd0, 0);
        send_request(tmpr_pkg::CMD_RENDER, 13'h0000, 8'h00, 8'd255, 8'd255, 1);
        wait_idle();

        // Random phases, one control setting each, extremes included
        phase_control[0] = 8'h00;
        phase_control[1] = 8'hFF;
        phase_control[2] = 8'h40;
        phase_control[3] = 8'h10;
        phase_control[4] = 8'hAF;
        phase_control[5] = 8'h50;
        phase_control[6] = 8'($urandom);
        phase_control[7] = 8'($urandom);
        foreach (phase_control[p]) begin
            write_control(phase_control[p]);
            phase_items = items_sent;
            while (items_sent - phase_items < (ITEMS_TARGET - 23) / 8) begin
                no_idle = ($urandom_range(0, 4) == 0);
                kind    = $urandom_range(0, 9);
                if (kind <= 6) begin
                    run_tile_row();
                end else if (kind == 7) begin
                    // Stray write anywhere in video memory
                    send_request(tmpr_pkg::CMD_WRITE, 13'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), draw_gap());
                end else if (kind == 8) begin
                    // Render any pixel the fields allow
                    send_request(tmpr_pkg::CMD_RENDER, 13'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), draw_gap());
                end else begin
                    run_stray_row();
                end
            end
            wait_idle();
        end

        repeat (RESULT_SETTLE) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
